// ===== sv/msort_pkg.sv =====
// Shared definitions for the merge sorter: data word width and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package msort_pkg;

	// Width of one element of the run.
	localparam int WORD_W = 32;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_PAIR  = 5'b00010,
		ST_MERGE = 5'b00100,
		ST_OREAD = 5'b01000,
		ST_OHOLD = 5'b10000
	} state_t;

endpackage

// ===== sv/msort_ram.sv =====
// Generic RAM for the merge sorter: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_a_q;
	logic [WIDTH-1:0] rd_data_b_q;

	// Write port and both registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a_q <= mem_q[rd_addr_a];
		rd_data_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

// ===== sv/merge_sorter.sv =====
// Top level of the merge sorter: load sequencer, bottom-up merge engine and result output.
// Depends on msort_pkg and msort_ram.
`timescale 1ns / 1ps

// The block collects a run of signed 32-bit values, one per input transfer, until a
// transfer with last set arrives or CAPACITY values are held, and then returns the run
// sorted ascending (stable, ties keep their input order) as one result transfer per value,
// with final_res set on the last. The sort then makes ceil(log2(n)) passes over n values,
// ping-ponging between two RAMs; each pass sets up each pair of merged runs in ST_PAIR,
// merges that pair in ST_MERGE and turns the pass in ST_PAIR again, all through the
// single compare-and-write unit and the two read ports of the source RAM. Each result is
// then read from the RAM in ST_OREAD and presented in ST_OHOLD, where it is held while
// out_stall is set. No new run is accepted until the final result of the current run
// has been transferred.
module merge_sorter
	import msort_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] sorted_value,
	output logic                     final_res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = CW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] n_q, n_d;
	logic [EW-1:0] width_q, width_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic          src_q, src_d;
	logic          out_valid_q, out_valid_d;
	logic [WORD_W-1:0] sorted_value_q, sorted_value_d;
	logic          final_q, final_d;

	logic              wr_en, wr_sel;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr_a, rd_addr_b;
	logic [WORD_W-1:0] ram0_a, ram0_b, ram1_a, ram1_b;
	logic [WORD_W-1:0] left_w, right_w;
	logic              take_left;
	logic [CW-1:0]     cnt_inc;
	logic [EW-1:0]     mid_e, hi_e;

	// Two buffers; each merge pass reads one and writes the other.
	msort_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram0 (
		.clk       (clk),
		.wr_en     (wr_en & ~wr_sel),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (ram0_a),
		.rd_data_b (ram0_b)
	);

	msort_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram1 (
		.clk       (clk),
		.wr_en     (wr_en & wr_sel),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (ram1_a),
		.rd_data_b (ram1_b)
	);

	// Read data from the current source buffer.
	assign left_w  = src_q ? ram1_a : ram0_a;
	assign right_w = src_q ? ram1_b : ram0_b;

	// Stable merge choice: the left run wins ties and the right run once exhausted.
	assign take_left = (i_q < mid_q) &&
		(!(j_q < hi_q) || ($signed(left_w) <= $signed(right_w)));

	// Sequencer.
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		n_d            = n_q;
		width_d        = width_q;
		lo_d           = lo_q;
		mid_d          = mid_q;
		hi_d           = hi_q;
		i_d            = i_q;
		j_d            = j_q;
		k_d            = k_q;
		src_d          = src_q;
		out_valid_d    = out_valid_q;
		sorted_value_d = sorted_value_q;
		final_d        = final_q;
		wr_en          = 1'b0;
		wr_sel         = 1'b0;
		wr_addr        = count_q[AW-1:0];
		wr_data        = value;
		rd_addr_a      = i_q[AW-1:0];
		rd_addr_b      = j_q[AW-1:0];
		cnt_inc        = count_q + 1'b1;
		mid_e          = EW'(lo_q) + width_q;
		hi_e           = mid_e + width_q;

		case (state_q)
			ST_LOAD: begin
				// Store each transferred value; the last one or a full buffer starts the sort.
				if (in_valid) begin
					wr_en = 1'b1;
					if (last || cnt_inc == CAP_C) begin
						n_d     = cnt_inc;
						count_d = '0;
						width_d = EW'(1);
						lo_d    = '0;
						src_d   = 1'b0;
						state_d = ST_PAIR;
					end else begin
						count_d = cnt_inc;
					end
				end
			end
			ST_PAIR: begin
				// Set up the next pair of runs, turn the pass, or finish the sort.
				if (width_q >= EW'(n_q)) begin
					k_d       = '0;
					rd_addr_a = '0;
					state_d   = ST_OREAD;
				end else if (lo_q >= n_q) begin
					width_d = width_q << 1;
					lo_d    = '0;
					src_d   = ~src_q;
				end else begin
					mid_d     = (mid_e > EW'(n_q)) ? n_q : mid_e[CW-1:0];
					hi_d      = (hi_e > EW'(n_q)) ? n_q : hi_e[CW-1:0];
					i_d       = lo_q;
					j_d       = mid_d;
					k_d       = lo_q;
					rd_addr_a = lo_q[AW-1:0];
					rd_addr_b = mid_d[AW-1:0];
					state_d   = ST_MERGE;
				end
			end
			ST_MERGE: begin
				// One element per cycle into the destination buffer, next reads issued at once.
				wr_en   = 1'b1;
				wr_sel  = ~src_q;
				wr_addr = k_q[AW-1:0];
				wr_data = take_left ? left_w : right_w;
				if (take_left) begin
					i_d = i_q + 1'b1;
				end else begin
					j_d = j_q + 1'b1;
				end
				k_d       = k_q + 1'b1;
				rd_addr_a = i_d[AW-1:0];
				rd_addr_b = j_d[AW-1:0];
				if (k_d == hi_q) begin
					lo_d    = hi_q;
					state_d = ST_PAIR;
				end
			end
			ST_OREAD: begin
				// Read data has arrived; load the output register.
				out_valid_d    = 1'b1;
				sorted_value_d = left_w;
				final_d        = ((k_q + 1'b1) == n_q);
				state_d        = ST_OHOLD;
			end
			ST_OHOLD: begin
				// Hold the result until it is transferred, then fetch the next one.
				if (!out_stall) begin
					out_valid_d = 1'b0;
					if (final_q) begin
						state_d = ST_LOAD;
					end else begin
						k_d       = k_q + 1'b1;
						rd_addr_a = k_d[AW-1:0];
						state_d   = ST_OREAD;
					end
				end
			end
			default: begin
				state_d     = ST_LOAD;
				count_d     = '0;
				out_valid_d = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			n_q         <= '0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			src_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			n_q         <= n_d;
			width_q     <= width_d;
			lo_q        <= lo_d;
			mid_q       <= mid_d;
			hi_q        <= hi_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			src_q       <= src_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		sorted_value_q <= sorted_value_d;
		final_q        <= final_d;
	end

	assign in_stall     = (state_q != ST_LOAD);
	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign final_res    = final_q;

endmodule
